/* src/mcpd_pkg.sv */
// ----------------------------------------------------------------------------
// mcpd_pkg
// Shared types and constants for the motor command packet decoder.
// ----------------------------------------------------------------------------
package mcpd_pkg;

  // Framing
  localparam logic [7:0] START_MARK = 8'hFF;
  localparam logic [7:0] DATA_FILL  = 8'hFF;

  // Escape byte codes
  localparam logic [7:0] ESC_LOWER = 8'd1;
  localparam logic [7:0] ESC_UPPER = 8'd2;
  localparam logic [7:0] ESC_BOTH  = 8'd3;

  // Raw command codes
  localparam logic [7:0] CMD_DUTY = 8'd0;
  localparam logic [7:0] CMD_CCW  = 8'd1;
  localparam logic [7:0] CMD_CW   = 8'd2;

  // Classified command kinds, as reported on the result
  localparam logic [1:0] KIND_DUTY    = 2'd0;
  localparam logic [1:0] KIND_CCW     = 2'd1;
  localparam logic [1:0] KIND_CW      = 2'd2;
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  // Reset values
  localparam logic [15:0] PERIOD_RESET = 16'd2000;
  localparam logic [15:0] DUTY_RESET   = 16'd250;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // One decoded packet, ready to execute
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] data;
  } pkt_t;

endpackage

/* src/mcpd_front.sv */
// ----------------------------------------------------------------------------
// mcpd_front
// Byte framer: tracks the packet position, holds command and data bytes,
// applies the escape byte and pushes one classified packet per frame.
// ----------------------------------------------------------------------------
module mcpd_front import mcpd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       queue_full,
  output logic       push,
  output pkt_t       push_data
);

  localparam logic [2:0] POS_IDLE  = 3'd0;
  localparam logic [2:0] POS_CMD   = 3'd1;
  localparam logic [2:0] POS_UPPER = 3'd2;
  localparam logic [2:0] POS_LOWER = 3'd3;
  localparam logic [2:0] POS_ESC   = 3'd4;

  logic [2:0] byte_position;
  logic [2:0] byte_position_next;
  logic [1:0] kind_held;
  logic [7:0] upper_held;
  logic [7:0] lower_held;
  logic       accept;
  logic [7:0] upper_fix;
  logic [7:0] lower_fix;

  assign in_stall = queue_full;
  assign accept   = in_valid && !in_stall;

  // Advance the packet position
  always_comb begin
    byte_position_next = byte_position;
    case (byte_position)
      POS_IDLE:  if (rx_byte == START_MARK) byte_position_next = POS_CMD;
      POS_CMD:   byte_position_next = POS_UPPER;
      POS_UPPER: byte_position_next = POS_LOWER;
      POS_LOWER: byte_position_next = POS_ESC;
      POS_ESC:   byte_position_next = POS_IDLE;
      default:   byte_position_next = POS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= POS_IDLE;
    end else if (accept) begin
      byte_position <= byte_position_next;
    end
  end

  // Hold the classified command and the data bytes
  always_ff @(posedge clk) begin
    if (accept) begin
      if (byte_position == POS_CMD) begin
        case (rx_byte)
          CMD_DUTY: kind_held <= KIND_DUTY;
          CMD_CCW:  kind_held <= KIND_CCW;
          CMD_CW:   kind_held <= KIND_CW;
          default:  kind_held <= KIND_UNKNOWN;
        endcase
      end
      if (byte_position == POS_UPPER) upper_held <= rx_byte;
      if (byte_position == POS_LOWER) lower_held <= rx_byte;
    end
  end

  // Restore data bytes named by the escape byte
  always_comb begin
    upper_fix = upper_held;
    lower_fix = lower_held;
    case (rx_byte)
      ESC_LOWER: lower_fix = DATA_FILL;
      ESC_UPPER: upper_fix = DATA_FILL;
      ESC_BOTH: begin
        lower_fix = DATA_FILL;
        upper_fix = DATA_FILL;
      end
      default: ;
    endcase
  end

  assign push           = accept && (byte_position == POS_ESC);
  assign push_data.kind = kind_held;
  assign push_data.data = {upper_fix, lower_fix};

endmodule

/* src/mcpd_queue.sv */
// ----------------------------------------------------------------------------
// mcpd_queue
// Small first-in first-out queue of decoded packets between front and back.
// ----------------------------------------------------------------------------
module mcpd_queue import mcpd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  pkt_t push_data,
  output logic full,
  output logic pop_valid,
  input  logic pop,
  output pkt_t pop_data
);

  pkt_t              entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                do_push;
  logic                do_pop;

  assign full      = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;
  assign pop_data  = entries[rd_ptr];

  // Store the pushed packet
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* src/mcpd_back.sv */
// ----------------------------------------------------------------------------
// mcpd_back
// Packet executor: scales duty data by the period (multiply stage), divides
// by full scale, updates compare and direction and drives the result.
// ----------------------------------------------------------------------------
module mcpd_back import mcpd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] pwm_period,
  input  logic        pop_valid,
  output logic        pop,
  input  pkt_t        pop_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] compare_value,
  output logic        dir_ccw,
  output logic [1:0]  cmd_kind
);

  logic        s1_valid;
  logic [1:0]  s1_kind;
  logic [31:0] s1_product;
  logic        s1_load;
  logic        out_load;
  logic [31:0] quot_sum;
  logic [15:0] quotient;
  logic [15:0] duty_compare;
  logic        direction_ccw;
  logic [15:0] duty_compare_next;
  logic        direction_ccw_next;

  assign out_load = s1_valid && (!out_valid || !out_stall);
  assign s1_load  = pop_valid && (!s1_valid || out_load);
  assign pop      = s1_load;

  // Multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_kind    <= pop_data.kind;
      s1_product <= pwm_period * pop_data.data;
    end
  end

  // Divide by 65535: floor(p / (2^16-1)) = (p + (p >> 16) + 1) >> 16
  assign quot_sum = s1_product + {16'd0, s1_product[31:16]} + 32'd1;
  assign quotient = quot_sum[31:16];

  // Apply the command to compare and direction
  always_comb begin
    duty_compare_next  = duty_compare;
    direction_ccw_next = direction_ccw;
    case (s1_kind)
      KIND_DUTY: duty_compare_next  = quotient;
      KIND_CCW:  direction_ccw_next = 1'b1;
      KIND_CW:   direction_ccw_next = 1'b0;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_compare  <= DUTY_RESET;
      direction_ccw <= 1'b0;
    end else if (out_load) begin
      duty_compare  <= duty_compare_next;
      direction_ccw <= direction_ccw_next;
    end
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      compare_value <= duty_compare_next;
      dir_ccw       <= direction_ccw_next;
      cmd_kind      <= s1_kind;
    end
  end

endmodule

/* src/motor_command_packet_decoder_unit.sv */
// ----------------------------------------------------------------------------
// motor_command_packet_decoder_unit
// Decodes five-byte motor command packets (start, command, upper, lower,
// escape) from a byte stream into PWM compare and direction updates.
//
// Usage:
//   Input in_valid/in_stall/rx_byte takes one byte per cycle if not stalled.
//   Output channel out_valid/out_stall carries one result per completed
//   packet: compare_value, dir_ccw and cmd_kind.
//   Configuration: cfg_write with cfg_data loads pwm_period (reset 2000).
//   Path: a packet whose escape byte is taken passes through the queue into
//   the multiply stage and then into the output register, where its result
//   is offered. Throughput: one byte per cycle while in_stall is low; the
//   multiply stage and the output register each handle one packet per cycle
//   while out_stall is low.
//   Reset (rst, synchronous) returns to awaiting a start byte, compare 250,
//   clockwise, empty queue.
//   When out_stall holds, the result register and multiply stage hold and
//   up to four packets collect in the queue; in_stall rises only when the
//   queue is full.
// ----------------------------------------------------------------------------
module motor_command_packet_decoder_unit import mcpd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] compare_value,
  output logic        dir_ccw,
  output logic [1:0]  cmd_kind
);

  logic [15:0] pwm_period;
  logic        push;
  pkt_t        push_data;
  logic        queue_full;
  logic        pop_valid;
  logic        pop;
  pkt_t        pop_data;

  // Hold the period register
  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period <= PERIOD_RESET;
    end else if (cfg_write) begin
      pwm_period <= cfg_data;
    end
  end

  mcpd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  mcpd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_data  (pop_data)
  );

  mcpd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .pwm_period    (pwm_period),
    .pop_valid     (pop_valid),
    .pop           (pop),
    .pop_data      (pop_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .compare_value (compare_value),
    .dir_ccw       (dir_ccw),
    .cmd_kind      (cmd_kind)
  );

endmodule
